FILE: rtl/core/ntbf_pkg.sv
// ----------------------------------------------------------------------------
// ntbf_pkg
// Types, constants and control store for the NTB16 transmit framer sequencer.
// ----------------------------------------------------------------------------
package ntbf_pkg;

  // block framing constants
  localparam logic [31:0] NTH16_SIGNATURE = 32'h484D434E;  // "NCMH"
  localparam logic [31:0] NDP16_SIGNATURE = 32'h304D434E;  // "NCM0"
  localparam logic [11:0] HDR_BYTES       = 12'd12;
  localparam logic [15:0] NDP_BYTES       = 16'd8;

  // configuration register indexes
  localparam logic CFG_MAX_BLOCK_SIZE     = 1'b0;
  localparam logic CFG_MAX_DATAGRAM_LIMIT = 1'b1;

  // input op codes
  localparam logic OP_ALLOCATE = 1'b0;
  localparam logic OP_FLUSH    = 1'b1;

  // result kinds
  localparam logic KIND_WORD  = 1'b0;
  localparam logic KIND_PLACE = 1'b1;

  // sequencer step addresses
  typedef logic [3:0] step_t;
  localparam step_t STEP_IDLE      = 4'd0;
  localparam step_t STEP_CHK_FLUSH = 4'd1;
  localparam step_t STEP_CHK_CLOSE = 4'd2;
  localparam step_t STEP_HDR_SIG   = 4'd3;
  localparam step_t STEP_HDR_SEQ   = 4'd4;
  localparam step_t STEP_HDR_LEN   = 4'd5;
  localparam step_t STEP_NDP_SIG   = 4'd6;
  localparam step_t STEP_NDP_LEN   = 4'd7;
  localparam step_t STEP_NDP_PTR   = 4'd8;
  localparam step_t STEP_NDP_TERM  = 4'd9;
  localparam step_t STEP_PLACE     = 4'd10;

  // word source of an emitting step
  typedef enum logic [2:0] {
    WSEL_HDR_SIG,
    WSEL_HDR_SEQ,
    WSEL_HDR_LEN,
    WSEL_NDP_SIG,
    WSEL_NDP_LEN,
    WSEL_NDP_PTR,
    WSEL_NDP_TERM,
    WSEL_PLACE
  } wsel_e;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_EMPTY_FLUSH,
    COND_NO_CLOSE,
    COND_MORE_PTRS,
    COND_FLUSH
  } cond_e;

  // datapath actions, taken when the step retires
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LATCH,
    ACT_IDX_CLEAR,
    ACT_IDX_INC,
    ACT_CLOSE,
    ACT_PLACE
  } act_e;

  // last flag source
  typedef enum logic [1:0] {
    LAST_NONE,
    LAST_ONE,
    LAST_IF_FLUSH
  } last_e;

  typedef struct packed {
    logic  emit;
    wsel_e wsel;
    last_e lsel;
    act_e  act;
    cond_e cond;
    step_t target;
  } ucode_t;

  // control store
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t uw;
    uw = '{emit: 1'b0, wsel: WSEL_PLACE, lsel: LAST_NONE, act: ACT_NONE,
           cond: COND_ALWAYS, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        uw.act    = ACT_LATCH;
        uw.cond   = COND_NO_INPUT;
        uw.target = STEP_IDLE;
      end
      STEP_CHK_FLUSH: begin
        uw.cond   = COND_EMPTY_FLUSH;
        uw.target = STEP_IDLE;
      end
      STEP_CHK_CLOSE: begin
        uw.cond   = COND_NO_CLOSE;
        uw.target = STEP_PLACE;
      end
      STEP_HDR_SIG: begin
        uw.emit = 1'b1;
        uw.wsel = WSEL_HDR_SIG;
        uw.cond = COND_NEVER;
      end
      STEP_HDR_SEQ: begin
        uw.emit = 1'b1;
        uw.wsel = WSEL_HDR_SEQ;
        uw.cond = COND_NEVER;
      end
      STEP_HDR_LEN: begin
        uw.emit = 1'b1;
        uw.wsel = WSEL_HDR_LEN;
        uw.cond = COND_NEVER;
      end
      STEP_NDP_SIG: begin
        uw.emit = 1'b1;
        uw.wsel = WSEL_NDP_SIG;
        uw.cond = COND_NEVER;
      end
      STEP_NDP_LEN: begin
        uw.emit = 1'b1;
        uw.wsel = WSEL_NDP_LEN;
        uw.act  = ACT_IDX_CLEAR;
        uw.cond = COND_NEVER;
      end
      STEP_NDP_PTR: begin
        uw.emit   = 1'b1;
        uw.wsel   = WSEL_NDP_PTR;
        uw.act    = ACT_IDX_INC;
        uw.cond   = COND_MORE_PTRS;
        uw.target = STEP_NDP_PTR;
      end
      STEP_NDP_TERM: begin
        uw.emit   = 1'b1;
        uw.wsel   = WSEL_NDP_TERM;
        uw.lsel   = LAST_IF_FLUSH;
        uw.act    = ACT_CLOSE;
        uw.cond   = COND_FLUSH;
        uw.target = STEP_IDLE;
      end
      STEP_PLACE: begin
        uw.emit   = 1'b1;
        uw.wsel   = WSEL_PLACE;
        uw.lsel   = LAST_ONE;
        uw.act    = ACT_PLACE;
        uw.cond   = COND_ALWAYS;
        uw.target = STEP_IDLE;
      end
      default: begin
        uw.cond   = COND_ALWAYS;
        uw.target = STEP_IDLE;
      end
    endcase
    return uw;
  endfunction

endpackage

FILE: rtl/core/ntb16_transmit_framer.sv
// ----------------------------------------------------------------------------
// ntb16_transmit_framer
// Packs datagram allocations into NTB16 transfer blocks and emits the block
// framing as 32-bit word writes, driven by a small microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+---------------------------
//  in       | input     | in_valid_i / in_ready_o  | op_i, datagram_length_i
//  out      | output    | out_valid_o / out_ready_i| kind_o, byte_offset_o,
//           |           |                          | word_value_o, too_big_o,
//           |           |                          | last_o
//  cfg      | input     | cfg_we_i (no wait)       | cfg_index_i, cfg_wdata_i
//
//  One item at a time: the sequencer runs one control store step per cycle
//  unless an emitting step holds. An allocate runs the check and place steps;
//  a close adds header, ndp, pointer and terminator steps, an empty flush only
//  the flush check. Each emitting step holds while the output register is full
//  and not taken. Reset clears the offset, count and sequence state; the
//  pointer table is not cleared, only entries below the count are read.
// ----------------------------------------------------------------------------
module ntb16_transmit_framer #(
  parameter int MAX_ENTRIES  = 10,
  parameter int BUFFER_BYTES = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  // input words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [10:0] datagram_length_i,
  // output words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [10:0] byte_offset_o,
  output logic [31:0] word_value_o,
  output logic        too_big_o,
  output logic        last_o
);
  import ntbf_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [16:0] BUF_LIM   = 17'(BUFFER_BYTES);
  localparam logic [15:0] MAX_ENT16 = 16'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

  // configuration registers
  logic [11:0] max_block_size_q;
  logic [15:0] max_dgram_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_block_size_q  <= 12'd2048;
      max_dgram_limit_q <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAX_BLOCK_SIZE:     max_block_size_q  <= cfg_wdata_i[11:0];
        CFG_MAX_DATAGRAM_LIMIT: max_dgram_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // state
  step_t            pc_q, pc_d;
  logic             op_q;
  logic [10:0]      len_q;
  logic [11:0]      wo_q, wo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]      seq_q, seq_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [22:0]      ptr_rd_q;
  logic [22:0]      ptr_mem [MAX_ENTRIES];

  logic        out_valid_q;
  logic        kind_q, big_q, last_q;
  logic [10:0] off_q;
  logic [31:0] word_q;

  ucode_t uw;
  logic   out_free, step_go, cond_hit, in_accept;

  // effective limits
  logic [16:0] eff_limit;
  logic [15:0] eff_max;

  always_comb begin
    eff_limit = ({5'b0, max_block_size_q} > BUF_LIM) ? BUF_LIM : {5'b0, max_block_size_q};
    eff_max   = (max_dgram_limit_q == 16'd0 || max_dgram_limit_q > MAX_ENT16) ?
                MAX_ENT16 : max_dgram_limit_q;
  end

  // size check with alignment padding, ndp, entries and terminator
  function automatic logic fits(input logic [11:0] off, input logic [10:0] len,
                                input logic [CNT_W-1:0] count, input logic [16:0] lim);
    logic [16:0] sum;
    logic [16:0] end_b;
    sum   = 17'(off) + 17'(len) + 17'd3;
    end_b = {sum[16:2], 2'b00} + 17'(NDP_BYTES) + ((17'(count) + 17'd2) << 2);
    return end_b <= lim;
  endfunction

  logic        fit_now, need_close, place_ok;
  logic [12:0] wo_sum;
  logic [12:0] ndp;
  logic [15:0] blen, ndp_len;

  always_comb begin
    fit_now    = fits(wo_q, len_q, cnt_q, eff_limit);
    need_close = !fit_now || ((16'(cnt_q) + 16'd1) > eff_max);
    place_ok   = fit_now && (cnt_q < MAX_CNT);
    wo_sum     = {1'b0, wo_q} + 13'd3;
    ndp        = {wo_sum[12:2], 2'b00};
    ndp_len    = NDP_BYTES + ((16'(cnt_q) + 16'd1) << 2);
    blen       = 16'(ndp) + ndp_len;
  end

  // control word and sequencing
  assign uw        = ucode_rom(pc_q);
  assign out_free  = !out_valid_q || out_ready_i;
  assign step_go   = !uw.emit || out_free;
  assign in_ready_o = (pc_q == STEP_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    case (uw.cond)
      COND_NEVER:       cond_hit = 1'b0;
      COND_ALWAYS:      cond_hit = 1'b1;
      COND_NO_INPUT:    cond_hit = !in_accept;
      COND_EMPTY_FLUSH: cond_hit = (op_q == OP_FLUSH) && (cnt_q == '0);
      COND_NO_CLOSE:    cond_hit = (op_q == OP_ALLOCATE) && (!need_close || cnt_q == '0);
      COND_MORE_PTRS:   cond_hit = (CNT_W'(idx_q) + CNT_W'(1)) != cnt_q;
      COND_FLUSH:       cond_hit = (op_q == OP_FLUSH);
      default:          cond_hit = 1'b1;
    endcase
  end

  // next step
  always_comb begin
    pc_d = pc_q;
    if (step_go) begin
      pc_d = cond_hit ? uw.target : pc_q + step_t'(1);
    end
  end

  // datapath actions
  always_comb begin
    wo_d  = wo_q;
    cnt_d = cnt_q;
    seq_d = seq_q;
    idx_d = idx_q;
    if (step_go) begin
      case (uw.act)
        ACT_IDX_CLEAR: idx_d = '0;
        ACT_IDX_INC:   idx_d = idx_q + IDX_W'(1);
        ACT_CLOSE: begin
          wo_d  = HDR_BYTES;
          cnt_d = '0;
          seq_d = seq_q + 16'd1;
        end
        ACT_PLACE: begin
          if (place_ok) begin
            wo_d  = wo_q + {1'b0, len_q};
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= STEP_IDLE;
      wo_q  <= HDR_BYTES;
      cnt_q <= '0;
      seq_q <= 16'd0;
      idx_q <= '0;
    end else begin
      pc_q  <= pc_d;
      wo_q  <= wo_d;
      cnt_q <= cnt_d;
      seq_q <= seq_d;
      idx_q <= idx_d;
    end
  end

  // latch the accepted word
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= op_i;
      len_q <= datagram_length_i;
    end
  end

  // pointer table, read one step ahead of the emitting step
  always_ff @(posedge clk_i) begin
    if (step_go && uw.act == ACT_PLACE && place_ok) begin
      ptr_mem[cnt_q[IDX_W-1:0]] <= {len_q, wo_q};
    end
    ptr_rd_q <= ptr_mem[idx_d];
  end

  // output word selection
  logic        ld_kind, ld_big, ld_last;
  logic [10:0] ld_off;
  logic [31:0] ld_word;

  always_comb begin
    ld_kind = KIND_WORD;
    ld_big  = 1'b0;
    ld_off  = '0;
    ld_word = '0;
    case (uw.wsel)
      WSEL_HDR_SIG: begin
        ld_off  = 11'd0;
        ld_word = NTH16_SIGNATURE;
      end
      WSEL_HDR_SEQ: begin
        ld_off  = 11'd4;
        ld_word = {seq_q, 4'b0, HDR_BYTES};
      end
      WSEL_HDR_LEN: begin
        ld_off  = 11'd8;
        ld_word = {3'b0, ndp, blen};
      end
      WSEL_NDP_SIG: begin
        ld_off  = ndp[10:0];
        ld_word = NDP16_SIGNATURE;
      end
      WSEL_NDP_LEN: begin
        ld_off  = ndp[10:0] + 11'd4;
        ld_word = {16'b0, ndp_len};
      end
      WSEL_NDP_PTR: begin
        ld_off  = ndp[10:0] + 11'd8 + (11'(idx_q) << 2);
        ld_word = {5'b0, ptr_rd_q[22:12], 4'b0, ptr_rd_q[11:0]};
      end
      WSEL_NDP_TERM: begin
        ld_off  = ndp[10:0] + 11'd8 + (11'(cnt_q) << 2);
        ld_word = '0;
      end
      WSEL_PLACE: begin
        ld_kind = KIND_PLACE;
        ld_big  = !place_ok;
        ld_off  = place_ok ? wo_q[10:0] : 11'd0;
        ld_word = {21'b0, len_q};
      end
      default: ;
    endcase
    case (uw.lsel)
      LAST_ONE:      ld_last = 1'b1;
      LAST_IF_FLUSH: ld_last = (op_q == OP_FLUSH);
      default:       ld_last = 1'b0;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= uw.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uw.emit && out_free) begin
      kind_q <= ld_kind;
      off_q  <= ld_off;
      word_q <= ld_word;
      big_q  <= ld_big;
      last_q <= ld_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign byte_offset_o = off_q;
  assign word_value_o  = word_q;
  assign too_big_o     = big_q;
  assign last_o        = last_q;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAX_CNT) else $error("entry count above table depth");

  a_empty_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wo_q == HDR_BYTES)) else $error("empty block with moved offset");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == STEP_NDP_TERM && step_go) |=> (cnt_q == '0 && wo_q == HDR_BYTES))
    else $error("close did not reset the block");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_ready_o) else $error("new word taken while sequencer busy");

  a_big_is_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && too_big_o) |-> (kind_o == KIND_PLACE))
    else $error("rejected flag on a block word write");

endmodule

FILE: test/ntbf_checker.sv
// ----------------------------------------------------------------------------
// ntbf_checker
// Watches the configuration, input and output channels of the NTB16 transmit
// framer. It keeps its own copy of the framing state, predicts the word writes
// and placement reports for each accepted input word and compares every
// accepted output word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module ntbf_checker #(
  parameter int MAX_ENTRIES  = 10,
  parameter int BUFFER_BYTES = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        op_i,
  input  logic [10:0] datagram_length_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        kind_i,
  input  logic [10:0] byte_offset_i,
  input  logic [31:0] word_value_i,
  input  logic        too_big_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);
  import ntbf_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [10:0] byte_offset;
    logic [31:0] word_value;
    logic        too_big;
    logic        last;
  } frame_word_t;

  // words still owed by the block, oldest first
  frame_word_t awaited_words[$];
  frame_word_t oldest;

  // mirrored registers and framing state
  logic [11:0] block_size;
  logic [15:0] datagram_limit;
  logic [11:0] write_offset;
  int unsigned entry_count;
  logic [15:0] sequence_number;
  logic [31:0] pointer_table [MAX_ENTRIES];

  int fails;
  int words_seen;

  assign fail_count_o = fails;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ntbf_checker: word %0d %s: got 0x%0h, want 0x%0h", words_seen, what,
             got, want);
    fails++;
  endtask

  function automatic int unsigned align4(input int unsigned v);
    return (v + 32'd3) & ~32'd3;
  endfunction

  // does a datagram of this length fit behind the open block's data
  function automatic bit datagram_fits(input int unsigned len);
    int unsigned lim;
    lim = (block_size > BUFFER_BYTES) ? BUFFER_BYTES : block_size;
    return align4(write_offset + len) + NDP_BYTES + 4 * (entry_count + 2) <= lim;
  endfunction

  function automatic void owe_word(input logic kind, input int unsigned off,
                                   input logic [31:0] value, input logic big,
                                   input logic last);
    frame_word_t w;
    w.kind        = kind;
    w.byte_offset = off[10:0];
    w.word_value  = value;
    w.too_big     = big;
    w.last        = last;
    awaited_words.push_back(w);
  endfunction

  // emit header, ndp, pointer entries and terminator, then open a new block
  function automatic void close_block(input logic mark_last);
    int unsigned ndp;
    int unsigned blen;
    if (entry_count == 0) return;
    ndp  = align4(write_offset);
    blen = ndp + NDP_BYTES + 4 * (entry_count + 1);
    owe_word(KIND_WORD, 0, NTH16_SIGNATURE, 1'b0, 1'b0);
    owe_word(KIND_WORD, 4, {sequence_number, 16'(HDR_BYTES)}, 1'b0, 1'b0);
    owe_word(KIND_WORD, 8, {ndp[15:0], blen[15:0]}, 1'b0, 1'b0);
    owe_word(KIND_WORD, ndp, NDP16_SIGNATURE, 1'b0, 1'b0);
    owe_word(KIND_WORD, ndp + 4, NDP_BYTES + 4 * (entry_count + 1), 1'b0, 1'b0);
    for (int unsigned i = 0; i < entry_count; i++)
      owe_word(KIND_WORD, ndp + NDP_BYTES + 4 * i, pointer_table[i], 1'b0, 1'b0);
    owe_word(KIND_WORD, ndp + NDP_BYTES + 4 * entry_count, 32'd0, 1'b0, mark_last);
    write_offset    = HDR_BYTES;
    entry_count     = 0;
    sequence_number = sequence_number + 16'd1;
  endfunction

  // work out the words caused by one input word
  function automatic void advance_framer(input logic op, input logic [10:0] len);
    int unsigned cap;
    if (op == OP_FLUSH) begin
      close_block(1'b1);
      return;
    end
    cap = (datagram_limit == 0 || datagram_limit > MAX_ENTRIES) ? MAX_ENTRIES
                                                                : datagram_limit;
    if (!datagram_fits(len) || entry_count + 1 > cap) close_block(1'b0);
    if (!datagram_fits(len) || entry_count >= MAX_ENTRIES) begin
      owe_word(KIND_PLACE, 0, 32'(len), 1'b1, 1'b1);
    end else begin
      pointer_table[entry_count] = {5'd0, len, 4'd0, write_offset};
      owe_word(KIND_PLACE, write_offset, 32'(len), 1'b0, 1'b1);
      write_offset = 12'(write_offset + len);
      entry_count++;
    end
  endfunction

  // compare outputs first: a word leaving now belongs to an earlier input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_words.delete();
      block_size      = 12'd2048;
      datagram_limit  = 16'd0;
      write_offset    = HDR_BYTES;
      entry_count     = 0;
      sequence_number = 16'd0;
      fails           = 0;
      words_seen      = 0;
      pending_o       <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_words.size() == 0) begin
          report_mismatch("arrived with nothing owed, value", word_value_i, 32'd0);
        end else begin
          oldest = awaited_words.pop_front();
          if (kind_i !== oldest.kind)
            report_mismatch("kind", 32'(kind_i), 32'(oldest.kind));
          if (byte_offset_i !== oldest.byte_offset)
            report_mismatch("byte_offset", 32'(byte_offset_i), 32'(oldest.byte_offset));
          if (word_value_i !== oldest.word_value)
            report_mismatch("word_value", word_value_i, oldest.word_value);
          if (too_big_i !== oldest.too_big)
            report_mismatch("too_big", 32'(too_big_i), 32'(oldest.too_big));
          if (last_i !== oldest.last)
            report_mismatch("last", 32'(last_i), 32'(oldest.last));
        end
        words_seen++;
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MAX_BLOCK_SIZE) block_size = cfg_wdata_i[11:0];
        else datagram_limit = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) advance_framer(op_i, datagram_length_i);
      pending_o <= awaited_words.size();
    end
  end

endmodule

FILE: test/tb_ntb16_transmit_framer.sv
// ----------------------------------------------------------------------------
// tb_ntb16_transmit_framer
// Drives allocate and flush words into the NTB16 transmit framer under several
// block size and datagram limit settings, with random gaps on the input and
// random stalls on the output. A checker beside the block predicts and
// compares every output word; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_ntb16_transmit_framer;
  import ntbf_pkg::*;

  localparam int STALL_MAX     = 19;
  localparam int SETTLE_CYCLES = 20;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 21;
  localparam int NUM_PHASES    = 7;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        cfg_we_i          = 1'b0;
  logic        cfg_index_i       = CFG_MAX_BLOCK_SIZE;
  logic [15:0] cfg_wdata_i       = 16'd0;
  logic        in_valid_i        = 1'b0;
  logic        op_i              = OP_ALLOCATE;
  logic [10:0] datagram_length_i = 11'd0;
  logic        out_ready_i       = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        kind_o;
  logic [10:0] byte_offset_o;
  logic [31:0] word_value_o;
  logic        too_big_o;
  logic        last_o;

  int fail_count;
  int pending;
  int quiet_cycles = 0;
  bit quiet_phase  = 1'b0;

  // block sizes and datagram limits of the random phases
  int phase_block_size [NUM_PHASES] = '{12, 2048, 2048, 100, 2048, 0, 512};
  int phase_dgram_limit[NUM_PHASES] = '{1, 1, 65535, 3, 10, 0, 0};

  always #4 clk_i = ~clk_i;

  ntb16_transmit_framer i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .op_i,
    .datagram_length_i,
    .out_valid_o,
    .out_ready_i,
    .kind_o,
    .byte_offset_o,
    .word_value_o,
    .too_big_o,
    .last_o
  );

  ntbf_checker i_frame_check (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_i        (in_ready_o),
    .op_i,
    .datagram_length_i,
    .out_valid_i       (out_valid_o),
    .out_ready_i,
    .kind_i            (kind_o),
    .byte_offset_i     (byte_offset_o),
    .word_value_i      (word_value_o),
    .too_big_i         (too_big_o),
    .last_i            (last_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  function automatic int draw_gap();
    return quiet_phase ? 0 : $urandom_range(0, STALL_MAX);
  endfunction

  // present one input word; valid stays high across back-to-back words
  task automatic send_word(input logic op, input logic [10:0] len);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    op_i              <= op;
    datagram_length_i <= len;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // hold off until every owed word is out and the block is idle
  task automatic drain_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limits(input int block_size, input int dgram_limit);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_MAX_BLOCK_SIZE;
    cfg_wdata_i <= 16'(block_size);
    @(posedge clk_i);
    cfg_index_i <= CFG_MAX_DATAGRAM_LIMIT;
    cfg_wdata_i <= 16'(dgram_limit);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // output side: random stall before taking each word
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_ntb16_transmit_framer: FAIL");
      $finish;
    end
  end

  initial begin
    logic op;
    logic [10:0] len;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero length, then one that fits no block and closes the first
    send_word(OP_ALLOCATE, 11'd0);
    send_word(OP_ALLOCATE, 11'd2047);
    // flush of an empty block
    send_word(OP_FLUSH, 11'd0);
    // odd lengths exercise the ndp alignment padding
    send_word(OP_ALLOCATE, 11'd1);
    send_word(OP_ALLOCATE, 11'd3);
    send_word(OP_ALLOCATE, 11'd5);
    send_word(OP_FLUSH, 11'd2047);
    // fill up to exactly the size limit, then one more closes the block
    send_word(OP_ALLOCATE, 11'd2000);
    send_word(OP_ALLOCATE, 11'd10);
    send_word(OP_ALLOCATE, 11'd1);
    send_word(OP_ALLOCATE, 11'd0);
    send_word(OP_FLUSH, 11'd0);
    // the eleventh datagram hits the entry limit
    for (int i = 0; i < 11; i++) send_word(OP_ALLOCATE, 11'($urandom_range(0, 40)));
    send_word(OP_FLUSH, 11'd0);

    // random phases, each under its own limits
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_block();
      if (phase == 5)
        write_limits($urandom_range(12, 2048), $urandom_range(0, 65535));
      else
        write_limits(phase_block_size[phase], phase_dgram_limit[phase]);
      quiet_phase = (phase == 2 || phase == 5);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        op  = ($urandom_range(0, 7) == 0) ? OP_FLUSH : OP_ALLOCATE;
        len = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 2047))
                                          : 11'($urandom_range(0, 255));
        send_word(op, len);
      end
    end
    quiet_phase = 1'b0;

    drain_block();
    if (fail_count == 0) begin
      $display("tb_ntb16_transmit_framer: PASS");
    end else begin
      $display("tb_ntb16_transmit_framer: FAIL");
    end
    $finish;
  end

endmodule
